// ----- rtl/tri_pkg.sv -----
// tri_pkg: shared types, constants and codes for the triangle rasterizer
// no dependencies
package tri_pkg;

    localparam int DEF_IMG_W = 64;
    localparam int DEF_IMG_H = 64;

    localparam logic CMD_DRAW = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [0:0] REG_WIDTH  = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic        command;
        logic [14:0] v0_x;
        logic [14:0] v0_y;
        logic [14:0] v1_x;
        logic [14:0] v1_y;
        logic [14:0] v2_x;
        logic [14:0] v2_y;
        logic [31:0] v0_attr;
        logic [31:0] v1_attr;
        logic [31:0] v2_attr;
        logic [11:0] pixel_addr;
    } t_in_word;

    typedef struct packed {
        logic [23:0] pixel_rgb;
        logic [7:0]  pixel_label;
        logic [12:0] pixels_written;
    } t_out_word;

    // one classified job handed from front to back
    typedef struct packed {
        logic               is_read;
        logic               degen;
        logic               neg;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] e0x;
        logic signed [15:0] e0y;
        logic signed [15:0] e1x;
        logic signed [15:0] e1y;
        logic [31:0]        d;
        logic [6:0]         x0;
        logic [6:0]         y0;
        logic [6:0]         x1;
        logic [6:0]         y1;
        logic [31:0]        at0;
        logic [31:0]        at1;
        logic [31:0]        at2;
        logic [11:0]        addr;
    } t_job;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CLEAR, ST_READ, ST_READ_OUT, ST_PIX, ST_EDGE,
        ST_TEST, ST_MUL, ST_DIV, ST_WRITE, ST_NEXT, ST_DONE
    } t_back_state;

endpackage

// ----- rtl/tri_front.sv -----
// tri_front: takes commands, computes edges, area and clipped box, pushes jobs
// depends on tri_pkg
module tri_front
    import tri_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_in_word    i_word,
    input  logic [12:0] i_w,
    input  logic [12:0] i_h,
    input  logic        i_full,
    output logic        o_busy,
    output logic        o_push,
    output t_job        o_job
);
    logic               r_have;
    t_in_word           r_word;
    logic               r_stage;
    logic signed [15:0] ax, ay, bx, by, cx, cy;
    logic signed [15:0] r_e0x, r_e0y, r_e1x, r_e1y;
    logic signed [32:0] r_p0, r_p1;
    logic signed [32:0] dd;
    logic [14:0]        mnx, mny, mxx, mxy;
    logic [15:0]        cxm, cym;
    logic [12:0]        x1c, y1c;

    assign ax = {1'b0, r_word.v0_x};
    assign ay = {1'b0, r_word.v0_y};
    assign bx = {1'b0, r_word.v1_x};
    assign by = {1'b0, r_word.v1_y};
    assign cx = {1'b0, r_word.v2_x};
    assign cy = {1'b0, r_word.v2_y};

    assign o_busy = r_have;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have  <= 1'b0;
            r_stage <= 1'b0;
        end else if (!r_have) begin
            if (i_valid) begin
                r_have  <= 1'b1;
                r_stage <= 1'b0;
            end
        end else if (!r_stage) begin
            r_stage <= 1'b1;
        end else if (!i_full) begin
            r_have <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_have && i_valid) begin
            r_word <= i_word;
        end
        if (r_have && !r_stage) begin
            r_e0x <= bx - ax;
            r_e0y <= by - ay;
            r_e1x <= cx - ax;
            r_e1y <= cy - ay;
            r_p0  <= 33'(signed'(bx - ax) * signed'(cy - ay));
            r_p1  <= 33'(signed'(by - ay) * signed'(cx - ax));
        end
    end

    always_comb begin
        mnx = r_word.v0_x;
        if (r_word.v1_x < mnx) mnx = r_word.v1_x;
        if (r_word.v2_x < mnx) mnx = r_word.v2_x;
        mny = r_word.v0_y;
        if (r_word.v1_y < mny) mny = r_word.v1_y;
        if (r_word.v2_y < mny) mny = r_word.v2_y;
        mxx = r_word.v0_x;
        if (r_word.v1_x > mxx) mxx = r_word.v1_x;
        if (r_word.v2_x > mxx) mxx = r_word.v2_x;
        mxy = r_word.v0_y;
        if (r_word.v1_y > mxy) mxy = r_word.v1_y;
        if (r_word.v2_y > mxy) mxy = r_word.v2_y;
        cxm = (16'(mxx) + 16'd255) >> 8;
        cym = (16'(mxy) + 16'd255) >> 8;
        x1c = (13'(cxm) > i_w - 13'd1) ? i_w - 13'd1 : 13'(cxm);
        y1c = (13'(cym) > i_h - 13'd1) ? i_h - 13'd1 : 13'(cym);
        dd  = r_p0 - r_p1;
    end

    assign o_push = r_have && r_stage && !i_full;

    always_comb begin
        o_job.is_read = (r_word.command == CMD_READ);
        o_job.degen   = (dd == 33'sd0);
        o_job.neg     = dd[32];
        o_job.ax      = ax;
        o_job.ay      = ay;
        o_job.e0x     = r_e0x;
        o_job.e0y     = r_e0y;
        o_job.e1x     = r_e1x;
        o_job.e1y     = r_e1y;
        o_job.d       = dd[32] ? 32'(-dd) : 32'(dd);
        o_job.x0      = 7'(mnx >> 8);
        o_job.y0      = 7'(mny >> 8);
        o_job.x1      = 7'(x1c);
        o_job.y1      = 7'(y1c);
        o_job.at0     = r_word.v0_attr;
        o_job.at1     = r_word.v1_attr;
        o_job.at2     = r_word.v2_attr;
        o_job.addr    = r_word.pixel_addr;
    end
endmodule

// ----- rtl/tri_queue.sv -----
// tri_queue: two-entry job queue between front and back
// depends on tri_pkg
module tri_queue
    import tri_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_job
);
    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("queue underflow");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
endmodule

// ----- rtl/tri_div.sv -----
// tri_div: restoring divider, one quotient bit per cycle, result clamped to 255
// no dependencies beyond tri_pkg
module tri_div
    import tri_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [41:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [7:0]  o_q
);
    logic [41:0] r_num;
    logic [41:0] r_quo;
    logic [32:0] r_rem;
    logic [5:0]  r_cnt;
    logic        r_run;
    logic [32:0] trial;

    assign trial = {r_rem[31:0], r_num[41]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && r_cnt == 6'd41) begin
                r_run  <= 1'b0;
                o_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= 33'd0;
            r_quo <= 42'd0;
            r_cnt <= 6'd0;
        end else if (r_run) begin
            r_num <= {r_num[40:0], 1'b0};
            r_cnt <= r_cnt + 6'd1;
            if (trial >= {1'b0, i_den}) begin
                r_rem <= trial - {1'b0, i_den};
                r_quo <= {r_quo[40:0], 1'b1};
            end else begin
                r_rem <= trial;
                r_quo <= {r_quo[40:0], 1'b0};
            end
        end
    end

    assign o_q = (r_quo[41:8] != 34'd0) ? 8'hFF : r_quo[7:0];
endmodule

// ----- rtl/tri_back.sv -----
// tri_back: clears stores after reset, serves reads, walks the box, shades and writes pixels
// depends on tri_pkg, tri_div
module tri_back
    import tri_pkg::*;
#(
    parameter int IMG_W = DEF_IMG_W,
    parameter int IMG_H = DEF_IMG_H
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_job        i_job,
    input  logic [12:0] i_w,
    input  logic [12:0] i_h,
    output logic        o_pop,
    output logic        o_idle,
    output logic        o_strobe,
    output t_out_word   o_word
);
    localparam int DEPTH = IMG_W * IMG_H;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [7:0]  r_lab_mem [DEPTH];
    logic [23:0] r_col_mem [DEPTH];

    t_back_state r_st, n_st;
    t_job        r_job;
    logic [AW:0] r_clr;
    logic [6:0]  r_x, r_y;
    logic [12:0] r_count;
    logic signed [33:0] r_nv, r_nw, r_nu;
    logic [1:0]  r_ch;
    logic [23:0] r_rgb;
    logic [7:0]  r_rd_lab;
    logic [23:0] r_rd_col;
    logic [24:0] r_idx;
    logic        r_in_range;

    logic signed [33:0] qx, qy, nv_raw, nw_raw;
    logic [24:0] idx_c;
    logic [7:0]  c0, c1, c2, win_lab;
    logic [41:0] sum_c;
    logic        div_start, div_done;
    logic [7:0]  div_q;
    logic        we;
    logic [AW-1:0] waddr, raddr;
    logic [23:0] wcol;
    logic [7:0]  wlab;

    always_comb begin
        qx = 34'(signed'({1'b0, r_x, 8'h80})) - 34'(r_job.ax);
        qy = 34'(signed'({1'b0, r_y, 8'h80})) - 34'(r_job.ay);
        nv_raw = 34'(qx * r_job.e1y) - 34'(qy * r_job.e1x);
        nw_raw = 34'(r_job.e0x * qy) - 34'(r_job.e0y * qx);
        idx_c  = 25'((i_h - 13'd1 - 13'(r_y)) * i_w) + 25'(r_x);
        unique case (r_ch)
            2'd0:    begin c0 = r_job.at0[23:16]; c1 = r_job.at1[23:16];
                           c2 = r_job.at2[23:16]; end
            2'd1:    begin c0 = r_job.at0[15:8];  c1 = r_job.at1[15:8];
                           c2 = r_job.at2[15:8];  end
            default: begin c0 = r_job.at0[7:0];   c1 = r_job.at1[7:0];
                           c2 = r_job.at2[7:0];   end
        endcase
        win_lab = r_job.at0[31:24];
        if (r_nv > r_nu) win_lab = r_job.at1[31:24];
        if (r_nw > r_nu && r_nw > r_nv) win_lab = r_job.at2[31:24];
        // weighted channel sum, loaded into the divider on its start cycle
        sum_c = 42'(r_nu[32:0] * c0) + 42'(r_nv[32:0] * c1)
              + 42'(r_nw[32:0] * c2);
    end

    tri_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (sum_c),
        .i_den  (r_job.d),
        .o_done (div_done),
        .o_q    (div_q)
    );

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_CLEAR:    if (r_clr == (AW+1)'(DEPTH - 1)) n_st = ST_IDLE;
            ST_IDLE:     if (!i_empty) n_st = i_job.is_read ? ST_READ :
                                         (i_job.degen ? ST_DONE : ST_PIX);
            ST_READ:     n_st = ST_READ_OUT;
            ST_READ_OUT: n_st = ST_IDLE;
            ST_PIX:      n_st = (r_y > r_job.y1) ? ST_DONE :
                                (r_x > r_job.x1) ? ST_NEXT : ST_EDGE;
            ST_EDGE:     n_st = ST_TEST;
            ST_TEST:     n_st = (r_nu[33] || r_nv[33] || r_nw[33] || !r_in_range
                                 || r_rd_lab != 8'd0) ? ST_NEXT : ST_MUL;
            ST_MUL:      n_st = ST_DIV;
            ST_DIV:      if (div_done) n_st = (r_ch == 2'd2) ? ST_WRITE : ST_MUL;
            ST_WRITE:    n_st = ST_NEXT;
            ST_NEXT:     n_st = ST_PIX;
            ST_DONE:     n_st = ST_IDLE;
            default:     n_st = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_pop     = (r_st == ST_IDLE) && !i_empty;
        o_idle    = (r_st == ST_IDLE) && i_empty;
        div_start = (r_st == ST_MUL);
        we        = (r_st == ST_CLEAR) || (r_st == ST_WRITE);
        waddr     = (r_st == ST_CLEAR) ? r_clr[AW-1:0] : r_idx[AW-1:0];
        wcol      = (r_st == ST_CLEAR) ? 24'd0 : r_rgb;
        wlab      = (r_st == ST_CLEAR) ? 8'd0 : win_lab;
        // label of the new pixel is fetched while its weights are formed
        raddr     = (r_st == ST_READ) ? r_job.addr[AW-1:0] :
                    (r_st == ST_EDGE) ? idx_c[AW-1:0] : r_idx[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_CLEAR;
            r_clr    <= '0;
            o_strobe <= 1'b0;
        end else begin
            r_st     <= n_st;
            o_strobe <= (r_st == ST_READ_OUT) || (r_st == ST_DONE);
            if (r_st == ST_CLEAR) r_clr <= r_clr + (AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_lab_mem[waddr] <= wlab;
            r_col_mem[waddr] <= wcol;
        end
        r_rd_lab <= r_lab_mem[raddr];
        r_rd_col <= r_col_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job   <= i_job;
            r_x     <= i_job.x0;
            r_y     <= i_job.y0;
            r_count <= 13'd0;
        end
        unique case (r_st)
            ST_EDGE: begin
                r_nv <= r_job.neg ? -nv_raw : nv_raw;
                r_nw <= r_job.neg ? -nw_raw : nw_raw;
                r_nu <= 34'(r_job.d) - (r_job.neg ? -nv_raw : nv_raw)
                        - (r_job.neg ? -nw_raw : nw_raw);
                r_idx      <= idx_c;
                r_in_range <= (idx_c < 25'(DEPTH));
                r_ch       <= 2'd0;
            end
            ST_DIV: if (div_done) begin
                r_rgb <= {r_rgb[15:0], div_q};
                r_ch  <= r_ch + 2'd1;
            end
            ST_WRITE: r_count <= r_count + 13'd1;
            ST_NEXT: begin
                if (r_x > r_job.x1) begin
                    r_x <= r_job.x0;
                    r_y <= r_y + 7'd1;
                end else begin
                    r_x <= r_x + 7'd1;
                end
            end
            default: ;
        endcase
        if (r_st == ST_READ_OUT) begin
            o_word.pixel_rgb      <= (r_job.addr < 12'(DEPTH) || DEPTH > 4095)
                                     ? r_rd_col : 24'd0;
            o_word.pixel_label    <= (r_job.addr < 12'(DEPTH) || DEPTH > 4095)
                                     ? r_rd_lab : 8'd0;
            o_word.pixels_written <= 13'd0;
        end else if (r_st == ST_DONE) begin
            o_word.pixel_rgb      <= 24'd0;
            o_word.pixel_label    <= 8'd0;
            o_word.pixels_written <= r_count;
        end
    end

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe) else $error("double result strobe");
    a_write_tested: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_WRITE) |-> (r_rd_lab == 8'd0 && r_in_range))
        else $error("write to occupied pixel");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_st == ST_IDLE)) else $error("pop while working");
endmodule

// ----- rtl/triangle_rasterizer_core.sv -----
// triangle_rasterizer_core: top level, config registers, front, queue, back
// depends on tri_pkg, tri_front, tri_queue, tri_back, tri_div
//
// Commands are taken when start is high and busy low. Each command gives
// exactly one result word, shown for one cycle with o_done; the receiver
// cannot stall it. A draw is set up in the front, then walks its box pixel by
// pixel and row by row, and for each covered free pixel runs three divisions
// (load, 42 quotient bits, done) and one write, paced by the one shared
// bit-serial divider. After reset the label and colour memories are cleared,
// all IMG_W*IMG_H entries, during which busy stays high; config writes are
// taken at any time but should be made only while the block is idle.
module triangle_rasterizer_core
    import tri_pkg::*;
#(
    parameter int IMG_W = DEF_IMG_W,
    parameter int IMG_H = DEF_IMG_H
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_word  i_word,
    output logic      o_done,
    output t_out_word o_word,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [0:0] i_cfg_index,
    input  logic [6:0] i_cfg_data
);
    logic [6:0]  r_aw, r_ah;
    logic [12:0] w_eff, h_eff;
    logic        front_busy, push, full, empty, pop, back_idle, clearing;
    t_job        fjob, qjob;
    logic [1:0]  r_pend;

    // config writes always accepted
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aw <= 7'd64;
            r_ah <= 7'd64;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_WIDTH:  r_aw <= i_cfg_data;
                REG_HEIGHT: r_ah <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // saturate to 1..IMG_W / 1..IMG_H
    always_comb begin
        w_eff = (r_aw == 7'd0) ? 13'd1 :
                (13'(r_aw) > 13'(IMG_W)) ? 13'(IMG_W) : 13'(r_aw);
        h_eff = (r_ah == 7'd0) ? 13'd1 :
                (13'(r_ah) > 13'(IMG_H)) ? 13'(IMG_H) : 13'(r_ah);
    end

    // one command in flight; busy also covers the clear pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_pend <= 2'd0;
        else r_pend <= r_pend + 2'(start && !busy) - 2'(o_done);
    end

    assign clearing = !back_idle && r_pend == 2'd0 && empty && !front_busy;
    assign busy     = (r_pend != 2'd0) || clearing;

    tri_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(start && !busy),
        .i_word (i_word),
        .i_w    (w_eff),
        .i_h    (h_eff),
        .i_full (full),
        .o_busy (front_busy),
        .o_push (push),
        .o_job  (fjob)
    );

    tri_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_job  (fjob),
        .i_pop  (pop),
        .o_full (full),
        .o_empty(empty),
        .o_job  (qjob)
    );

    tri_back #(.IMG_W(IMG_W), .IMG_H(IMG_H)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_job   (qjob),
        .i_w     (w_eff),
        .i_h     (h_eff),
        .o_pop   (pop),
        .o_idle  (back_idle),
        .o_strobe(o_done),
        .o_word  (o_word)
    );

    a_one_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= 2'd1) else $error("more than one command pending");
    a_done_has_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> r_pend == 2'd1) else $error("result without command");
    a_take_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("busy not raised after accept");
endmodule
